FILE: src/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the priority scheduler
// Record layout, time widths, sequencer states and shared unit operations.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int ARR_W       = 16;
  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int TIME_W      = 22;
  localparam int PIDX_W      = 5;
  localparam int IN_W        = ARR_W + BURST_W + PRIO_W;
  localparam int OUT_FIELD_W = PIDX_W + 4 * TIME_W;
  localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int MAX_PROCESSES_DEF = 32;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CT,
    ST_TAT,
    ST_WT,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

endpackage

FILE: src/nonpreemptive_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_top: non-preemptive priority scheduler
// Loads process records, then emits one schedule item per process.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one process record per item (arrival, burst, priority),
//   s_tlast marks the final record of a set. Records load one per cycle;
//   records beyond MAX_PROCESSES are dropped, a dropped final record still
//   starts scheduling of the records held.
//   m_* channel: one item per scheduled process in run order (index, start,
//   completion, turnaround, waiting), m_tlast on the final one of the set.
//   Each pick scans the record store through its single read port and then
//   decides; a second scan and decision follow when the clock has to jump to
//   the earliest pending arrival, then three steps on the shared adder
//   (completion, turnaround, waiting) and one to hand the item over.
//   s_tready is high only while no set is being scheduled.
//   A stalled receiver holds the result register; the sequencer waits there.
//   Reset clears the load count, done flags, clock and output valid; store
//   contents are left as they are.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_top #(
  parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
  input  logic [nps_pkg::IN_W-1:0]    s_tdata,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // process_index[4:0], start_time[26:5], completion_time[48:27],
  // turnaround_time[70:49], waiting_time[92:71], zero fill[95:93]
  output logic [nps_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tlast
);

  localparam int IDX_W    = $clog2(MAX_PROCESSES);
  localparam int CNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int TIME_W   = nps_pkg::TIME_W;
  localparam int ARR_W    = nps_pkg::ARR_W;
  localparam int PAD_W    = nps_pkg::OUT_W - nps_pkg::OUT_FIELD_W;
  localparam int PIDX_EXT = nps_pkg::PIDX_W;

  nps_pkg::state_t   state, state_next;
  nps_pkg::alu_req_t alu_req;
  nps_pkg::record_t  rdata;

  logic [TIME_W-1:0]        alu_res;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         completed;
  logic [MAX_PROCESSES-1:0] done;
  logic [TIME_W-1:0]        clock_time;
  logic [IDX_W-1:0]         scan_idx;
  logic                     issue_done;
  logic                     p_valid;
  logic [IDX_W-1:0]         p_idx;
  logic                     found;
  logic [IDX_W-1:0]         best_idx;
  nps_pkg::record_t         best;
  logic [ARR_W-1:0]         min_arr;
  logic [TIME_W-1:0]        ct;
  logic [TIME_W-1:0]        tat;
  logic [TIME_W-1:0]        wt;

  logic             in_fire;
  logic             count_lt;
  logic             scan_end;
  logic             scan_init;
  logic             emit_fire;
  logic             last_pick;
  logic             eligible;
  logic             better;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W+PIDX_EXT-1:0] best_idx_ext;

  assign in_fire   = s_tvalid && s_tready;
  assign count_lt  = count < CNT_W'(MAX_PROCESSES);
  assign count_m1  = count - CNT_W'(1);
  assign scan_end  = p_valid && (CNT_W'(p_idx) == count_m1);
  assign last_pick = completed == count_m1;
  assign emit_fire = (state == nps_pkg::ST_EMIT) && (!m_tvalid || m_tready);
  assign scan_init = (state_next == nps_pkg::ST_SCAN) && (state != nps_pkg::ST_SCAN);

  assign eligible = !done[p_idx] && (TIME_W'(rdata.arrival) <= clock_time);
  assign better   = !found || (rdata.prio < best.prio) ||
                    ((rdata.prio == best.prio) && (rdata.arrival < best.arrival));

  assign best_idx_ext = {{PIDX_EXT{1'b0}}, best_idx};

  nps_mem #(
    .DEPTH (MAX_PROCESSES),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk  (clk),
    .we   (in_fire && count_lt),
    .waddr(count[IDX_W-1:0]),
    .wdata(nps_pkg::record_t'(s_tdata)),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  nps_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      nps_pkg::ST_IDLE:   if (in_fire && s_tlast) state_next = nps_pkg::ST_SCAN;
      nps_pkg::ST_SCAN:   if (scan_end) state_next = nps_pkg::ST_DECIDE;
      nps_pkg::ST_DECIDE: state_next = found ? nps_pkg::ST_CT : nps_pkg::ST_SCAN;
      nps_pkg::ST_CT:     state_next = nps_pkg::ST_TAT;
      nps_pkg::ST_TAT:    state_next = nps_pkg::ST_WT;
      nps_pkg::ST_WT:     state_next = nps_pkg::ST_EMIT;
      nps_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = last_pick ? nps_pkg::ST_IDLE : nps_pkg::ST_SCAN;
        end
      end
      default:            state_next = nps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    alu_req.op = nps_pkg::ALU_ADD;
    alu_req.a  = clock_time;
    alu_req.b  = TIME_W'(best.burst);
    unique case (state)
      nps_pkg::ST_IDLE: s_tready = 1'b1;
      nps_pkg::ST_TAT: begin
        alu_req.op = nps_pkg::ALU_SUB;
        alu_req.a  = ct;
        alu_req.b  = TIME_W'(best.arrival);
      end
      nps_pkg::ST_WT: begin
        alu_req.op = nps_pkg::ALU_SUB;
        alu_req.a  = tat;
        alu_req.b  = TIME_W'(best.burst);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nps_pkg::ST_IDLE;
      count      <= '0;
      completed  <= '0;
      done       <= '0;
      clock_time <= '0;
      m_tvalid   <= 1'b0;
      p_valid    <= 1'b0;
      issue_done <= 1'b0;
      scan_idx   <= '0;
      found      <= 1'b0;
    end else begin
      state <= state_next;

      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (in_fire) begin
        if (count_lt) begin
          count <= count + CNT_W'(1);
        end
        if (s_tlast) begin
          clock_time <= '0;
          done       <= '0;
          completed  <= '0;
        end
      end

      if (scan_init) begin
        scan_idx   <= '0;
        issue_done <= 1'b0;
        p_valid    <= 1'b0;
        found      <= 1'b0;
        min_arr    <= '1;
      end else if (state == nps_pkg::ST_SCAN) begin
        p_valid <= !issue_done;
        p_idx   <= scan_idx;
        if (!issue_done) begin
          if (CNT_W'(scan_idx) == count_m1) begin
            issue_done <= 1'b1;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        if (p_valid && !done[p_idx]) begin
          if (rdata.arrival < min_arr) begin
            min_arr <= rdata.arrival;
          end
          if (eligible && better) begin
            found    <= 1'b1;
            best     <= rdata;
            best_idx <= p_idx;
          end
        end
      end

      unique case (state)
        nps_pkg::ST_DECIDE: begin
          if (!found) begin
            clock_time <= TIME_W'(min_arr);
          end
        end
        nps_pkg::ST_CT:  ct  <= alu_res;
        nps_pkg::ST_TAT: tat <= alu_res;
        nps_pkg::ST_WT:  wt  <= alu_res;
        default: begin
        end
      endcase

      if (emit_fire) begin
        m_tlast        <= last_pick;
        m_tdata        <= {{PAD_W{1'b0}}, wt, tat, ct, clock_time,
                           best_idx_ext[nps_pkg::PIDX_W-1:0]};
        done[best_idx] <= 1'b1;
        completed      <= completed + CNT_W'(1);
        clock_time     <= ct;
        if (last_pick) begin
          count <= '0;
        end
      end
    end
  end

endmodule

FILE: src/nps_mem.sv
// ----------------------------------------------------------------------------
// nps_mem: process record store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_mem #(
  parameter int DEPTH  = nps_pkg::MAX_PROCESSES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  nps_pkg::record_t     wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output nps_pkg::record_t     rdata
);

  nps_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nps_alu.sv
// ----------------------------------------------------------------------------
// nps_alu: shared time arithmetic unit
// Adds or subtracts two time values modulo the time width.
// ----------------------------------------------------------------------------
module nps_alu (
  input  nps_pkg::alu_req_t                 req,
  output logic [nps_pkg::TIME_W-1:0]        res
);

  always_comb begin
    unique case (req.op)
      nps_pkg::ALU_ADD: res = req.a + req.b;
      nps_pkg::ALU_SUB: res = req.a - req.b;
      default:          res = req.a + req.b;
    endcase
  end

endmodule
